>>> src/dsns_pkg.sv
// ----------------------------------------------------------------------------
// dsns_pkg: shared types and constants for the double SHA-256 nonce scan
// Word types, round constants, the initial hash value, register indexes,
// state machine encodings and the layout of the result beat.
// ----------------------------------------------------------------------------
`default_nettype none

package dsns_pkg;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned NONCE_W = 32;
  localparam int unsigned TRIED_W = 17;

  localparam int unsigned DEF_SCAN_SPAN_BITS = 16;
  localparam int unsigned DEF_ZERO_BITS      = 16;

  // Result beat layout, from bit 0 up: nonce_out, hashes_tried, digest words 0..7.
  localparam int unsigned NONCE_LSB   = 0;
  localparam int unsigned TRIED_LSB   = NONCE_LSB + NONCE_W;
  localparam int unsigned DIGEST_LSB  = TRIED_LSB + TRIED_W;
  localparam int unsigned DIGEST7_LSB = DIGEST_LSB + 7 * WORD_W;
  localparam int unsigned PAYLOAD_W   = DIGEST_LSB + 8 * WORD_W;
  localparam int unsigned TDATA_W     = ((PAYLOAD_W + 7) / 8) * 8;
  localparam int unsigned TDATA_PAD   = TDATA_W - PAYLOAD_W;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_MID_01  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MID_23  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MID_45  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MID_67  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TAIL_01 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TAIL_2  = 3'd5;

  // Padding words of the two message blocks
  localparam logic [WORD_W-1:0] PAD_BIT_WORD  = 32'h8000_0000;
  localparam logic [WORD_W-1:0] LEN_CHUNK2    = 32'h0000_0280;
  localparam logic [WORD_W-1:0] LEN_DIGEST    = 32'h0000_0100;

  typedef logic [7:0][WORD_W-1:0]  state_words_t;
  typedef logic [15:0][WORD_W-1:0] block_words_t;

  typedef struct packed {
    logic busy;
    logic done;
  } sha_status_t;

  typedef enum logic [1:0] {
    CS_IDLE,
    CS_ROUND,
    CS_FINAL
  } core_state_t;

  typedef enum logic [1:0] {
    SS_IDLE,
    SS_PASS1,
    SS_PASS2,
    SS_RESULT
  } scan_state_t;

  localparam logic [WORD_W-1:0] SHA_IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [WORD_W-1:0] SHA_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

endpackage

`default_nettype wire

>>> src/double_sha256_nonce_scan.sv
// ----------------------------------------------------------------------------
// double_sha256_nonce_scan: double SHA-256 nonce scan over a header tail
// Usage:
//   cfg channel: write midstate and header tail words while the block is idle
//     (cfg_ready is always high; indexes past the last register are ignored).
//   s_t* channel: one beat carries the start nonce. The block increments it,
//     hashes the header chunk from the midstate, hashes that digest again,
//     and stops on a zero low ZERO_BITS of digest word 7 or when the low
//     SCAN_SPAN_BITS of the nonce wrap to zero.
//   m_t* channel: one result beat per scan; m_tuser is the found flag.
// Sequencing: one compression runs on the single shared round unit (load,
//   64 rounds, chain add), and each nonce takes two compressions.
//   m_tvalid rises when a scan ends and s_tready rises with it, so a new
//   scan starts only after the last one has finished;
//   a full window holds 2^SCAN_SPAN_BITS nonces.
//   s_tready is high only while no scan runs.
// Reset clears config registers, the sequencer and the output valid.
// A stalled receiver holds the result in the output register; a finished scan
//   waits for that register to drain before it is written.
// ----------------------------------------------------------------------------
`default_nettype none

module double_sha256_nonce_scan #(
  parameter int unsigned SCAN_SPAN_BITS = dsns_pkg::DEF_SCAN_SPAN_BITS,
  parameter int unsigned ZERO_BITS      = dsns_pkg::DEF_ZERO_BITS
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              cfg_valid,
  output logic                             cfg_ready,
  input  wire [dsns_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire [63:0]                       cfg_data,
  input  wire                              s_tvalid,
  output logic                             s_tready,
  input  wire [dsns_pkg::NONCE_W-1:0]      s_tdata,   // start_nonce
  output logic                             m_tvalid,
  input  wire                              m_tready,
  // nonce_out, hashes_tried, digest_word_0 .. digest_word_7, zero fill
  output logic [dsns_pkg::TDATA_W-1:0]     m_tdata,
  output logic [0:0]                       m_tuser    // found
);

  localparam logic [63:0] SPAN_COUNT = 64'd1 << SCAN_SPAN_BITS;
  localparam logic [dsns_pkg::TRIED_W-1:0] EXHAUST_TRIED = SPAN_COUNT[dsns_pkg::TRIED_W-1:0];

  logic [63:0] mid_01, mid_23, mid_45, mid_67, tail_01;
  logic [31:0] tail_2;

  dsns_pkg::scan_state_t state, state_next;
  logic [dsns_pkg::NONCE_W-1:0] nonce, nonce_next;
  logic [dsns_pkg::TRIED_W-1:0] tried, tried_rep;

  dsns_pkg::sha_status_t  core_status;
  dsns_pkg::state_words_t core_digest, chain_mid, chain_iv, core_chain;
  dsns_pkg::block_words_t chunk2, padded, core_msg;

  logic core_start, sel_pass2, out_load, out_free;
  logic in_beat, hit, wrap, stop, cont;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_01  <= '0;
      mid_23  <= '0;
      mid_45  <= '0;
      mid_67  <= '0;
      tail_01 <= '0;
      tail_2  <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        dsns_pkg::REG_MID_01:  mid_01  <= cfg_data;
        dsns_pkg::REG_MID_23:  mid_23  <= cfg_data;
        dsns_pkg::REG_MID_45:  mid_45  <= cfg_data;
        dsns_pkg::REG_MID_67:  mid_67  <= cfg_data;
        dsns_pkg::REG_TAIL_01: tail_01 <= cfg_data;
        dsns_pkg::REG_TAIL_2:  tail_2  <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    in_beat  = s_tvalid && s_tready;
    hit      = (core_digest[7][ZERO_BITS-1:0] == '0);
    wrap     = (nonce[SCAN_SPAN_BITS-1:0] == '0);
    stop     = hit || wrap;
    out_free = !m_tvalid || m_tready;
    cont     = (state == dsns_pkg::SS_PASS2) && core_status.done && !stop;
    if (in_beat) begin
      nonce_next = s_tdata + 32'd1;
    end else if (cont) begin
      nonce_next = nonce + 32'd1;
    end else begin
      nonce_next = nonce;
    end
    tried_rep = hit ? tried : EXHAUST_TRIED;
  end

  // Message blocks and chain values for the two compressions
  always_comb begin
    chain_mid = {mid_67[31:0], mid_67[63:32], mid_45[31:0], mid_45[63:32],
                 mid_23[31:0], mid_23[63:32], mid_01[31:0], mid_01[63:32]};
    for (int k = 0; k < 8; k++) begin
      chain_iv[k] = dsns_pkg::SHA_IV[k];
    end
    chunk2     = '0;
    chunk2[0]  = tail_01[63:32];
    chunk2[1]  = tail_01[31:0];
    chunk2[2]  = tail_2;
    chunk2[3]  = nonce_next;
    chunk2[4]  = dsns_pkg::PAD_BIT_WORD;
    chunk2[15] = dsns_pkg::LEN_CHUNK2;
    padded      = '0;
    padded[7:0] = core_digest;
    padded[8]   = dsns_pkg::PAD_BIT_WORD;
    padded[15]  = dsns_pkg::LEN_DIGEST;
    core_chain = sel_pass2 ? chain_iv : chain_mid;
    core_msg   = sel_pass2 ? padded : chunk2;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      dsns_pkg::SS_IDLE:  if (s_tvalid) state_next = dsns_pkg::SS_PASS1;
      dsns_pkg::SS_PASS1: if (core_status.done) state_next = dsns_pkg::SS_PASS2;
      dsns_pkg::SS_PASS2: begin
        if (core_status.done) begin
          if (!stop) begin
            state_next = dsns_pkg::SS_PASS1;
          end else if (out_free) begin
            state_next = dsns_pkg::SS_IDLE;
          end else begin
            state_next = dsns_pkg::SS_RESULT;
          end
        end
      end
      dsns_pkg::SS_RESULT: if (out_free) state_next = dsns_pkg::SS_IDLE;
      default: state_next = dsns_pkg::SS_IDLE;
    endcase
  end

  always_comb begin
    s_tready   = 1'b0;
    core_start = 1'b0;
    sel_pass2  = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      dsns_pkg::SS_IDLE: begin
        s_tready   = 1'b1;
        core_start = s_tvalid;
      end
      dsns_pkg::SS_PASS1: begin
        core_start = core_status.done;
        sel_pass2  = core_status.done;
      end
      dsns_pkg::SS_PASS2: begin
        core_start = core_status.done && !stop;
        sel_pass2  = !(core_status.done && !stop);
        out_load   = core_status.done && stop && out_free;
      end
      dsns_pkg::SS_RESULT: begin
        sel_pass2 = 1'b1;
        out_load  = out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= dsns_pkg::SS_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    nonce <= nonce_next;
    if (in_beat) begin
      tried <= {{(dsns_pkg::TRIED_W-1){1'b0}}, 1'b1};
    end else if (cont) begin
      tried <= tried + 1'b1;
    end
    if (out_load) begin
      m_tdata <= {{dsns_pkg::TDATA_PAD{1'b0}}, core_digest, tried_rep, nonce};
      m_tuser <= hit;
    end
  end

  dsns_sha_core u_core (
    .clk    (clk),
    .rst    (rst),
    .start  (core_start),
    .chain  (core_chain),
    .msg    (core_msg),
    .status (core_status),
    .digest (core_digest)
  );

endmodule

`default_nettype wire

>>> src/dsns_sha_core.sv
// ----------------------------------------------------------------------------
// dsns_sha_core: iterative SHA-256 compression, one round per cycle
// A start pulse loads the message block and chain value; 64 rounds run on a
// shared round unit with a sliding 16-word schedule, then the chain is added.
// The chain input must stay stable until done.
// ----------------------------------------------------------------------------
`default_nettype none

module dsns_sha_core (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         start,
  input  wire dsns_pkg::state_words_t chain,
  input  wire dsns_pkg::block_words_t msg,
  output dsns_pkg::sha_status_t       status,
  output dsns_pkg::state_words_t      digest
);

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  dsns_pkg::core_state_t  state, state_next;
  logic [5:0]             round;
  logic                   done;
  dsns_pkg::state_words_t v;
  dsns_pkg::block_words_t w;

  logic [31:0] bsig0, bsig1, ch, maj, t1, t2;
  logic [31:0] ssig0, ssig1, w_new;

  // Round unit: v[0] is a, v[7] is h; w[0] is the word of this round.
  always_comb begin
    bsig1 = rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25);
    ch    = (v[4] & v[5]) ^ (~v[4] & v[6]);
    t1    = v[7] + bsig1 + ch + dsns_pkg::SHA_K[round] + w[0];
    bsig0 = rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22);
    maj   = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
    t2    = bsig0 + maj;
    ssig0 = rotr(w[1], 7) ^ rotr(w[1], 18) ^ (w[1] >> 3);
    ssig1 = rotr(w[14], 17) ^ rotr(w[14], 19) ^ (w[14] >> 10);
    w_new = w[0] + ssig0 + w[9] + ssig1;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      dsns_pkg::CS_IDLE:  if (start) state_next = dsns_pkg::CS_ROUND;
      dsns_pkg::CS_ROUND: if (round == 6'd63) state_next = dsns_pkg::CS_FINAL;
      dsns_pkg::CS_FINAL: state_next = dsns_pkg::CS_IDLE;
      default:            state_next = dsns_pkg::CS_IDLE;
    endcase
  end

  always_comb begin
    status.busy = (state != dsns_pkg::CS_IDLE);
    status.done = done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dsns_pkg::CS_IDLE;
      round <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == dsns_pkg::CS_FINAL);
      if (state == dsns_pkg::CS_ROUND) begin
        round <= round + 6'd1;
      end else begin
        round <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      dsns_pkg::CS_IDLE: begin
        if (start) begin
          v <= chain;
          w <= msg;
        end
      end
      dsns_pkg::CS_ROUND: begin
        v <= {v[6:4], v[3] + t1, v[2:0], t1 + t2};
        w <= {w_new, w[15:1]};
      end
      dsns_pkg::CS_FINAL: begin
        for (int k = 0; k < 8; k++) begin
          digest[k] <= chain[k] + v[k];
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

>>> src/dsns_checker.sv
// ----------------------------------------------------------------------------
// dsns_checker: port-level checks for the double SHA-256 nonce scan
// Watches the stream ports and the result beat contents.
// ----------------------------------------------------------------------------
`default_nettype none

module dsns_checker #(
  parameter int unsigned SCAN_SPAN_BITS = dsns_pkg::DEF_SCAN_SPAN_BITS,
  parameter int unsigned ZERO_BITS      = dsns_pkg::DEF_ZERO_BITS
) (
  input wire                          clk,
  input wire                          rst,
  input wire                          s_tvalid,
  input wire                          s_tready,
  input wire                          m_tvalid,
  input wire                          m_tready,
  input wire [dsns_pkg::TDATA_W-1:0]  m_tdata,
  input wire [0:0]                    m_tuser
);

  // s_tready drops once a scan starts, so no input beat right after another
  a_busy_after_beat: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input accepted on back-to-back cycles");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("stalled result beat changed");

  a_hit_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |->
      (m_tdata[dsns_pkg::DIGEST7_LSB +: ZERO_BITS] == '0))
    else $error("found flag without zero digest bits");

  a_miss_edge: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser[0]) |->
      (m_tdata[dsns_pkg::NONCE_LSB +: SCAN_SPAN_BITS] == '0))
    else $error("exhausted scan ended off the window edge");

endmodule

bind double_sha256_nonce_scan dsns_checker #(
  .SCAN_SPAN_BITS (SCAN_SPAN_BITS),
  .ZERO_BITS      (ZERO_BITS)
) u_dsns_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

`default_nettype wire
